// ===== rtl/core/rdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_BITS_DEF  = 31;
  localparam int RADIX_BITS      = 5;
  localparam int DIGIT_BITS      = 4;
  localparam int STEP_BITS       = 3;

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_IDLE     = 3'd0;
  localparam step_t STEP_DIV_INIT = 3'd1;
  localparam step_t STEP_DIV_STEP = 3'd2;
  localparam step_t STEP_PUSH     = 3'd3;
  localparam step_t STEP_POP      = 3'd4;
  localparam step_t STEP_EMIT     = 3'd5;
  localparam step_t STEP_ERR      = 3'd6;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_START,
    JC_BITS,
    JC_QUOT,
    JC_SP
  } jump_t;

  typedef struct packed {
    logic  load_in;
    logic  div_init;
    logic  div_step;
    logic  push;
    logic  pop;
    logic  emit;
    logic  emit_bad;
    logic  ret;
    jump_t jc;
    step_t target;
  } ctl_t;

  function automatic ctl_t rdc_rom(step_t s);
    ctl_t c;
    c = '{default: '0, jc: JC_NEXT};
    case (s)
      STEP_IDLE: begin
        c.load_in = 1'b1;
        c.jc      = JC_START;
        c.target  = STEP_ERR;
      end
      STEP_DIV_INIT: begin
        c.div_init = 1'b1;
      end
      STEP_DIV_STEP: begin
        c.div_step = 1'b1;
        c.jc       = JC_BITS;
        c.target   = STEP_DIV_STEP;
      end
      STEP_PUSH: begin
        c.push   = 1'b1;
        c.jc     = JC_QUOT;
        c.target = STEP_DIV_INIT;
      end
      STEP_POP: begin
        c.pop = 1'b1;
      end
      STEP_EMIT: begin
        c.emit   = 1'b1;
        c.ret    = 1'b1;
        c.jc     = JC_SP;
        c.target = STEP_POP;
      end
      STEP_ERR: begin
        c.emit_bad = 1'b1;
        c.jc       = JC_ALWAYS;
        c.target   = STEP_IDLE;
      end
      default: begin
        c.jc     = JC_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/radix_digit_converter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                              Handshake
// command   value, radix                       start & !busy
// result    digit, last_digit, bad_radix       valid, one cycle, no back-pressure
//
// A bad radix (below 2 or above 16) gives its result in the cycle right after
// acceptance.
// Each digit is worked out in the shared restoring divider (one quotient bit
// per cycle) and pushed on the stack, then later popped and emitted.
// No digit comes out before every division is done.
// Reset returns the sequencer to idle with an empty stack; busy stays high
// for the whole item.

module radix_digit_converter
#(
  parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [VALUE_BITS-1:0]          value,
  input  wire logic [rdc_pkg::RADIX_BITS-1:0] radix,
  output logic                                valid,
  output logic [rdc_pkg::DIGIT_BITS-1:0]      digit,
  output logic                                last_digit,
  output logic                                bad_radix
);

  import rdc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW = $clog2(VALUE_BITS + 1);

  step_t                 pc, pc_next;
  ctl_t                  ctl;
  logic [VALUE_BITS-1:0] quot;
  logic [DIGIT_BITS-1:0] rem;
  logic [RADIX_BITS-1:0] rad;
  logic [CW-1:0]         cnt;
  logic [SPW-1:0]        sp;
  logic [RADIX_BITS-1:0] trial;
  logic                  fits;
  logic                  in_bad;
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DIGIT_BITS-1:0] ram_rdata;
  step_t                 fall;

  assign ctl    = rdc_rom(pc);
  assign in_bad = !(radix inside {[5'd2:5'd16]});
  assign trial  = {rem, quot[VALUE_BITS-1]};
  assign fits   = (trial >= rad);
  assign fall   = ctl.ret ? STEP_IDLE : pc + step_t'(1);

  always_comb begin
    case (ctl.jc)
      JC_NEXT:   pc_next = fall;
      JC_ALWAYS: pc_next = ctl.target;
      JC_START:  pc_next = !start ? pc : (in_bad ? ctl.target : fall);
      JC_BITS:   pc_next = (cnt != CW'(1)) ? ctl.target : fall;
      JC_QUOT:   pc_next = (quot != '0) ? ctl.target : fall;
      JC_SP:     pc_next = (sp != '0) ? ctl.target : fall;
      default:   pc_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
      sp <= '0;
    end else begin
      pc <= pc_next;
      if (ctl.load_in && start) begin
        sp <= '0;
      end else if (ram_we) begin
        sp <= sp + SPW'(1);
      end else if (ctl.pop) begin
        sp <= sp - SPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in && start) begin
      quot <= value;
      rad  <= radix;
    end
    if (ctl.div_init) begin
      rem <= '0;
      cnt <= CW'(VALUE_BITS);
    end
    if (ctl.div_step) begin
      rem  <= fits ? DIGIT_BITS'(trial - rad) : trial[DIGIT_BITS-1:0];
      quot <= {quot[VALUE_BITS-2:0], fits};
      cnt  <= cnt - CW'(1);
    end
  end

  // drop remainders once the stack is full
  assign ram_we    = ctl.push && (sp < SPW'(STACK_DEPTH));
  assign ram_re    = ctl.pop;
  assign ram_raddr = AW'(sp - SPW'(1));

  rdc_ram #(
    .WIDTH(DIGIT_BITS),
    .DEPTH(STACK_DEPTH),
    .AW   (AW)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sp[AW-1:0]),
    .wdata(rem),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy       = (pc != STEP_IDLE);
  assign valid      = ctl.emit || ctl.emit_bad;
  assign digit      = ctl.emit ? ram_rdata : '0;
  assign last_digit = ctl.emit_bad || (sp == '0);
  assign bad_radix  = ctl.emit_bad;

endmodule

`default_nettype wire

// ===== rtl/core/rdc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== bench/radix_digit_checker.sv =====
`timescale 1ns / 1ps

module radix_digit_checker
#(
  parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [VALUE_BITS-1:0]          value,
  input  wire logic [rdc_pkg::RADIX_BITS-1:0] radix,
  input  wire logic                           valid,
  input  wire logic [rdc_pkg::DIGIT_BITS-1:0] digit,
  input  wire logic                           last_digit,
  input  wire logic                           bad_radix,
  output int                                  digit_errors,
  output int                                  digits_pending
);

  typedef struct packed {
    logic [rdc_pkg::DIGIT_BITS-1:0] digit;
    logic                           last;
    logic                           bad;
  } digit_rec_t;

  digit_rec_t expected_digits[$];

  initial begin
    digit_errors   = 0;
    digits_pending = 0;
  end

  task automatic convert_value(input logic [VALUE_BITS-1:0] v,
                               input logic [rdc_pkg::RADIX_BITS-1:0] r);
    logic [rdc_pkg::DIGIT_BITS-1:0] stack [STACK_DEPTH];
    int                             depth;
    longint unsigned                quot;
    longint unsigned                base;
    digit_rec_t                     rec;
    if (r < 2 || r > 16) begin
      rec.digit = '0;
      rec.last  = 1'b1;
      rec.bad   = 1'b1;
      expected_digits.push_back(rec);
    end else begin
      depth = 0;
      quot  = longint'(v);
      base  = longint'(r);
      if (quot == 0) begin
        stack[0] = '0;
        depth    = 1;
      end
      while (quot != 0) begin
        // drop remainders once the stack is full
        if (depth < STACK_DEPTH) begin
          stack[depth] = rdc_pkg::DIGIT_BITS'(quot % base);
          depth++;
        end
        quot = quot / base;
      end
      while (depth > 0) begin
        depth--;
        rec.digit = stack[depth];
        rec.last  = (depth == 0);
        rec.bad   = 1'b0;
        expected_digits.push_back(rec);
      end
    end
  endtask

  always @(posedge clk) begin
    digit_rec_t want;
    if (!rst) begin
      if (valid) begin
        if (expected_digits.size() == 0) begin
          if (digit_errors < 10)
            $display("%0t: unexpected digit %0d last %0b bad %0b", $realtime,
                     digit, last_digit, bad_radix);
          digit_errors++;
        end else begin
          want = expected_digits.pop_front();
          if (digit !== want.digit || last_digit !== want.last ||
              bad_radix !== want.bad) begin
            if (digit_errors < 10)
              $display("%0t: digit mismatch, expected %0d/%0b/%0b got %0d/%0b/%0b",
                       $realtime, want.digit, want.last, want.bad,
                       digit, last_digit, bad_radix);
            digit_errors++;
          end
        end
      end
      if (start && !busy)
        convert_value(value, radix);
      digits_pending = expected_digits.size();
    end
  end

endmodule

// ===== bench/tb_radix_digit_converter.sv =====
`timescale 1ns / 1ps

module tb_radix_digit_converter;

  localparam int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF;
  localparam int VALUE_BITS  = rdc_pkg::VALUE_BITS_DEF;
  localparam int RB          = rdc_pkg::RADIX_BITS;
  localparam int RANDOM_ITEMS = 320;
  localparam int STALL_LIMIT  = 8000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic [VALUE_BITS-1:0]          value = '0;
  logic [RB-1:0]                  radix = '0;
  logic                           valid;
  logic [rdc_pkg::DIGIT_BITS-1:0] digit;
  logic                           last_digit;
  logic                           bad_radix;
  int                             digit_errors;
  int                             digits_pending;
  bit                             idle_en = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  radix_digit_converter #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .radix     (radix),
    .valid     (valid),
    .digit     (digit),
    .last_digit(last_digit),
    .bad_radix (bad_radix)
  );

  radix_digit_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .radix         (radix),
    .valid         (valid),
    .digit         (digit),
    .last_digit    (last_digit),
    .bad_radix     (bad_radix),
    .digit_errors  (digit_errors),
    .digits_pending(digits_pending)
  );

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [VALUE_BITS-1:0] v, input logic [RB-1:0] r);
    start = 1'b0;
    while (busy || (idle_en && $urandom_range(99) < 21)) @(negedge clk);
    start = 1'b1;
    value = v;
    radix = r;
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (digits_pending != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = VALUE_BITS'({$urandom, $urandom});
      5, 6:          v = VALUE_BITS'($urandom_range(255));
      7:             v = {VALUE_BITS{1'b1}} >> $urandom_range(VALUE_BITS - 1);
      8:             v = VALUE_BITS'(1) << $urandom_range(VALUE_BITS - 1);
      default:       v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [RB-1:0] pick_radix();
    if ($urandom_range(9) < 8)
      return RB'($urandom_range(16, 2));
    return RB'($urandom_range((1 << RB) - 1));
  endfunction

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || valid)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("radix_digit_converter regression: fail");
    $finish;
  end

  initial begin
    logic [VALUE_BITS-1:0] all_ones;
    all_ones = '1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    send_item('0, RB'(10));
    send_item('0, RB'(2));
    send_item('0, RB'(16));
    send_item(all_ones, RB'(0));
    send_item(all_ones, RB'(1));
    send_item('0, RB'(0));
    send_item(all_ones, RB'(17));
    send_item(all_ones, RB'(31));
    send_item('0, RB'(24));
    send_item(all_ones, RB'(2));
    send_item(all_ones, RB'(3));
    send_item(all_ones, RB'(10));
    send_item(all_ones, RB'(16));
    send_item(VALUE_BITS'(1), RB'(2));
    send_item(VALUE_BITS'(15), RB'(16));
    send_item(VALUE_BITS'(16), RB'(16));
    send_item(VALUE_BITS'(1) << (VALUE_BITS - 1), RB'(2));
    send_item(VALUE_BITS'({(VALUE_BITS + 1) / 2{2'b10}}), RB'(2));
    send_item(VALUE_BITS'({(VALUE_BITS + 1) / 2{2'b01}}), RB'(7));
    send_item(VALUE_BITS'(999), RB'(10));
    send_item(VALUE_BITS'(1000), RB'(10));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_en = (i < 100 || i >= 180);
      send_item(pick_value(), pick_radix());
      if (i == 60 || i == 250)
        wait_drained();
    end
    start = 1'b0;

    while (digits_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (digit_errors == 0 && digits_pending == 0)
      $display("radix_digit_converter regression: pass");
    else
      $display("radix_digit_converter regression: fail");
    $finish;
  end

endmodule
